/* rtl/sfde_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfde_pkg: shared constants for the stereo feedback echo unit
// Sample widths, delay-line geometry, saturation limits and register codes.
// ----------------------------------------------------------------------------
package sfde_pkg;

  // Sample and word geometry
  localparam int SampleW  = 16;
  localparam int WordW    = 2 * SampleW;
  localparam int GainW    = 16;
  localparam int ProdW    = SampleW + GainW;
  localparam int SumW     = SampleW + 2;

  // Delay line geometry
  localparam int MaxDelay = 32768;
  localparam int AddrW    = $clog2(MaxDelay);
  localparam int CntW     = AddrW + 1;

  // Saturation limits for the feedback sum
  localparam logic signed [SumW-1:0] SatHi = SumW'(32767);
  localparam logic signed [SumW-1:0] SatLo = -SumW'(32767);

  // Configuration port
  localparam int CfgIdxW = 8;
  localparam int CfgDatW = 16;
  localparam logic [CfgIdxW-1:0] CfgDelay = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgGain  = CfgIdxW'(1);

  // Register reset values
  localparam logic [CfgDatW-1:0] DelayRst = CfgDatW'(1);
  localparam logic [GainW-1:0]   GainRst  = GainW'(32768);

endpackage

/* rtl/sfde_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfde_ram: generic simple dual-port RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module sfde_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read; old data on a same-address collision
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/sfde_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfde_lane: one channel of the feedback comb
// Scales the delayed sample by the Q0.16 gain (truncated toward zero), adds
// the new input and saturates to the symmetric 16-bit range.
// ----------------------------------------------------------------------------
module sfde_lane (
  input  logic signed [sfde_pkg::SampleW-1:0] x_i,
  input  logic signed [sfde_pkg::SampleW-1:0] y_i,
  input  logic        [sfde_pkg::GainW-1:0]   gain_i,
  output logic signed [sfde_pkg::SampleW-1:0] w_o
);

  logic                                neg;
  logic        [sfde_pkg::SampleW:0]   y_abs;
  logic        [sfde_pkg::ProdW-1:0]   prod;
  logic        [sfde_pkg::SumW-1:0]    mag_ext;
  logic signed [sfde_pkg::SumW-1:0]    term;
  logic signed [sfde_pkg::SumW-1:0]    sum;

  // Magnitude times gain, keep the integer part
  assign neg   = y_i[sfde_pkg::SampleW-1];
  assign y_abs = neg ? (sfde_pkg::SampleW+1)'(-$signed({y_i[sfde_pkg::SampleW-1], y_i}))
                     : {1'b0, y_i};
  assign prod  = y_abs[sfde_pkg::SampleW-1:0] * gain_i;
  assign mag_ext = {2'b00, prod[sfde_pkg::ProdW-1:sfde_pkg::GainW]};
  assign term  = neg ? -$signed(mag_ext) : $signed(mag_ext);

  // Add input and clamp
  assign sum = $signed({{2{x_i[sfde_pkg::SampleW-1]}}, x_i}) + term;

  always_comb begin
    priority if (sum > sfde_pkg::SatHi) begin
      w_o = sfde_pkg::SampleW'(sfde_pkg::SatHi);
    end else if (sum < sfde_pkg::SatLo) begin
      w_o = sfde_pkg::SampleW'(sfde_pkg::SatLo);
    end else begin
      w_o = sum[sfde_pkg::SampleW-1:0];
    end
  end

endmodule

/* rtl/stereo_feedback_delay_echo_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_feedback_delay_echo_unit: stereo feedback echo (comb filter)
// Each input stereo word yields one output word y = w delayed by D samples,
// where w = sat(x + g*y) is stored in a 32768-entry delay line.
//
// Usage:
//   s_axis: input samples, tdata = {right_sample, left_sample}.
//   m_axis: echo output,   tdata = {right_out, left_out}.
//   cfg:    register writes (index 0 delay_samples, index 1 decay_gain),
//           always ready; write only while the unit is idle.
// Flow: accepted words pass the compute stage, then the output register.
// Throughput: one word per cycle without a stall; the delay-line RAM takes one
//   read at acceptance and one write when the word leaves the compute stage,
//   and a one-entry bypass covers a read colliding with that write (delay 1).
// Reset: delay 1, gain 0.5, pointer 0; the delay line reads as zero until
//   written, tracked by a fill count, so no clearing pass is needed.
// Stall: when m_axis_tready is low the output and compute stages hold and
//   s_axis_tready drops once both are full; no word is lost.
// ----------------------------------------------------------------------------
module stereo_feedback_delay_echo_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input stream: [15:0] left_sample, [31:16] right_sample
  input  logic [sfde_pkg::WordW-1:0]    s_axis_tdata,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // Output stream: [15:0] left_out, [31:16] right_out
  output logic [sfde_pkg::WordW-1:0]    m_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // Configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sfde_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [sfde_pkg::CfgDatW-1:0]  cfg_data_i
);

  localparam int SW = sfde_pkg::SampleW;

  // Configuration and pointer state
  logic [sfde_pkg::CfgDatW-1:0] delay_q;
  logic [sfde_pkg::GainW-1:0]   gain_q;
  logic [sfde_pkg::AddrW-1:0]   ptr_q, ptr_d;
  logic [sfde_pkg::CntW-1:0]    fill_q, fill_d;

  // Compute stage
  logic                         s1_valid_q;
  logic                         s1_pass_q;
  logic                         s1_hit_q;
  logic                         s1_zero_q;
  logic [sfde_pkg::AddrW-1:0]   s1_addr_q;
  logic [sfde_pkg::WordW-1:0]   s1_x_q;
  logic [sfde_pkg::WordW-1:0]   byp_q;

  // Output register
  logic                         out_valid_q;
  logic [sfde_pkg::WordW-1:0]   out_data_q;

  logic                         in_fire, s1_fire;
  logic [sfde_pkg::CntW-1:0]    d_eff;
  logic                         pass_c, hit_c, zero_c;
  logic [sfde_pkg::AddrW-1:0]   ptr_base;
  logic [sfde_pkg::CntW-1:0]    ptr_inc;
  logic [sfde_pkg::CntW-1:0]    waddr_inc;
  logic [sfde_pkg::WordW-1:0]   rdata;
  logic [sfde_pkg::WordW-1:0]   y_word;
  logic [sfde_pkg::WordW-1:0]   lane_y;
  logic [sfde_pkg::WordW-1:0]   w_word;
  logic                         ram_we;

  // Handshakes
  assign s1_fire       = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_fire;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Clamp the delay and form this word's address
  assign d_eff    = (delay_q > sfde_pkg::CntW'(sfde_pkg::MaxDelay))
                    ? sfde_pkg::CntW'(sfde_pkg::MaxDelay) : delay_q;
  assign pass_c   = (d_eff == '0);
  assign ptr_base = ({1'b0, ptr_q} >= d_eff) ? '0 : ptr_q;
  assign ptr_inc  = {1'b0, ptr_base} + sfde_pkg::CntW'(1);
  assign ptr_d    = (ptr_inc >= d_eff) ? '0 : ptr_inc[sfde_pkg::AddrW-1:0];

  // Collision with the write leaving the compute stage at this edge
  assign ram_we = s1_fire && !s1_pass_q;
  assign hit_c  = ram_we && (s1_addr_q == ptr_base);
  assign zero_c = ({1'b0, ptr_base} >= fill_q);

  // Extend the written region of the delay line
  assign waddr_inc = {1'b0, s1_addr_q} + sfde_pkg::CntW'(1);
  assign fill_d    = (waddr_inc > fill_q) ? waddr_inc : fill_q;

  sfde_ram #(
    .Width (sfde_pkg::WordW),
    .Depth (sfde_pkg::MaxDelay)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_addr_q),
    .wdata_i (w_word),
    .re_i    (in_fire && !pass_c),
    .raddr_i (ptr_base),
    .rdata_o (rdata)
  );

  // Select the delayed word: bypass, unwritten entry or RAM
  always_comb begin
    priority if (s1_hit_q) begin
      y_word = byp_q;
    end else if (s1_zero_q) begin
      y_word = '0;
    end else begin
      y_word = rdata;
    end
  end

  // Passthrough feeds zero feedback so the lane gives sat(x)
  assign lane_y = s1_pass_q ? '0 : y_word;

  sfde_lane u_lane_l (
    .x_i    (s1_x_q[SW-1:0]),
    .y_i    (lane_y[SW-1:0]),
    .gain_i (gain_q),
    .w_o    (w_word[SW-1:0])
  );

  sfde_lane u_lane_r (
    .x_i    (s1_x_q[2*SW-1:SW]),
    .y_i    (lane_y[2*SW-1:SW]),
    .gain_i (gain_q),
    .w_o    (w_word[2*SW-1:SW])
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q     <= sfde_pkg::DelayRst;
      gain_q      <= sfde_pkg::GainRst;
      ptr_q       <= '0;
      fill_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == sfde_pkg::CfgDelay) begin
          delay_q <= cfg_data_i;
        end else if (cfg_index_i == sfde_pkg::CfgGain) begin
          gain_q <= cfg_data_i;
        end
      end
      if (in_fire && !pass_c) begin
        ptr_q <= ptr_d;
      end
      if (ram_we) begin
        fill_q <= fill_d;
      end
      if (s_axis_tready) begin
        s1_valid_q <= s_axis_tvalid;
      end
      if (!out_valid_q || m_axis_tready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pass_q <= pass_c;
      s1_hit_q  <= hit_c;
      s1_zero_q <= zero_c;
      s1_addr_q <= ptr_base;
      s1_x_q    <= s_axis_tdata;
    end
    if (s1_fire) begin
      byp_q      <= w_word;
      out_data_q <= s1_pass_q ? w_word : y_word;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

/* verif/tb_stereo_feedback_delay_echo_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stereo_feedback_delay_echo_unit: self-checking bench for the stereo echo
// Writes delay and gain settings between bursts of stereo words, from
// passthrough up to the longest delay line. A short table of hand-picked words
// comes first, then random bursts. Each output word is checked field by field
// against its typed table value or a comb-filter predictor that keeps its own
// delay line, pointer and settings. Inputs idle and outputs stall at random.
// ----------------------------------------------------------------------------
module tb_stereo_feedback_delay_echo_unit;
  import sfde_pkg::*;

  localparam int CycleLimit = 100000;
  localparam int NumBursts  = 12;
  localparam int BurstLen   = 45;
  localparam int NumRows    = 32;
  localparam logic [CfgIdxW-1:0] CfgSpare = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgTop   = {CfgIdxW{1'b1}};

  typedef enum logic {RowPair, RowReg} row_kind_e;

  // One directed step: a stereo word, or a register write (data in left)
  typedef struct {
    row_kind_e            kind;
    logic [CfgIdxW-1:0]   idx;
    logic [SampleW-1:0]   left;
    logic [SampleW-1:0]   right;
    bit                   typed;
    logic [SampleW-1:0]   want_l;
    logic [SampleW-1:0]   want_r;
  } row_t;

  // Hand-typed expectation travelling with each word sent
  typedef struct {
    bit               typed;
    logic [WordW-1:0] word;
  } hint_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic [WordW-1:0]   s_axis_tdata  = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [WordW-1:0]   m_axis_tdata;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic               cfg_valid_i   = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i   = '0;
  logic [CfgDatW-1:0] cfg_data_i    = '0;

  // Predictor state
  logic signed [SampleW-1:0] line_l [MaxDelay];
  logic signed [SampleW-1:0] line_r [MaxDelay];
  int echo_ptr   = 0;
  int echo_delay = int'(DelayRst);
  int echo_gain  = int'(GainRst);

  logic [WordW-1:0] echo_due [$];
  hint_t            typed_due [$];
  int               errors    = 0;
  int               cycle_cnt = 0;
  bit               calm      = 1'b0;
  row_t             rows [NumRows];

  stereo_feedback_delay_echo_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Saturate a sum to the symmetric sample range
  function automatic logic [SampleW-1:0] clip(int v);
    return SampleW'(v > 32767 ? 32767 : (v < -32767 ? -32767 : v));
  endfunction

  // Gain product, truncated toward zero
  function automatic int feedback(int y, int g);
    int mag;
    int p;
    mag = (y < 0) ? -y : y;
    p   = (mag * g) >> 16;
    return (y < 0) ? -p : p;
  endfunction

  // Advance the comb filter by one stereo word and return the echo word
  function automatic logic [WordW-1:0] echo_step(logic [WordW-1:0] word);
    int d;
    int xl;
    int xr;
    int yl;
    int yr;
    xl = int'($signed(word[SampleW-1:0]));
    xr = int'($signed(word[WordW-1:SampleW]));
    d  = (echo_delay > MaxDelay) ? MaxDelay : echo_delay;
    if (d == 0) begin
      return {clip(xr), clip(xl)};
    end
    if (echo_ptr >= d) echo_ptr = 0;
    yl = int'(line_l[echo_ptr]);
    yr = int'(line_r[echo_ptr]);
    line_l[echo_ptr] = clip(xl + feedback(yl, echo_gain));
    line_r[echo_ptr] = clip(xr + feedback(yr, echo_gain));
    echo_ptr++;
    if (echo_ptr >= d) echo_ptr = 0;
    return {SampleW'(yr), SampleW'(yl)};
  endfunction

  // Mostly full-range, with a share of rails and near-zero values
  function automatic logic [SampleW-1:0] pick_sample();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return SampleW'(int'($urandom_range(200)) - 100);
      default: return SampleW'($urandom);
    endcase
  endfunction

  // Track register writes, predict accepted words, check output words
  always @(posedge clk_i) begin : score
    logic [WordW-1:0] want;
    hint_t            hint;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgDelay: echo_delay = int'(cfg_data_i);
          CfgGain:  echo_gain  = int'(cfg_data_i);
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = echo_step(s_axis_tdata);
        hint = typed_due.pop_front();
        echo_due = {echo_due, (hint.typed ? hint.word : want)};
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (echo_due.size() == 0) begin
          $display("%0t: unexpected word, actual %h", $time, m_axis_tdata);
          errors++;
        end else begin
          want = echo_due.pop_front();
          if (m_axis_tdata[SampleW-1:0] !== want[SampleW-1:0]) begin
            $display("%0t: left_out expected %h actual %h", $time,
                     want[SampleW-1:0], m_axis_tdata[SampleW-1:0]);
            errors++;
          end
          if (m_axis_tdata[WordW-1:SampleW] !== want[WordW-1:SampleW]) begin
            $display("%0t: right_out expected %h actual %h", $time,
                     want[WordW-1:SampleW], m_axis_tdata[WordW-1:SampleW]);
            errors++;
          end
        end
      end
    end
  end

  // Stall the output side at random, except in calm stretches
  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 7);
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("stereo_feedback_delay_echo_unit test failed");
      $finish;
    end
  end

  // Send one stereo word, with a random gap ahead of it
  task automatic send_pair(logic [SampleW-1:0] left, logic [SampleW-1:0] right,
                           bit typed, logic [WordW-1:0] want);
    hint_t hint;
    while (!calm && $urandom_range(99) < 7) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    hint.typed = typed;
    hint.word  = want;
    typed_due = {typed_due, hint};
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {right, left};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Hold the input until every expected word is out, then let the pipe empty
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (echo_due.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Write one register while the unit is idle
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDatW-1:0] data);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    foreach (line_l[i]) begin
      line_l[i] = '0;
      line_r[i] = '0;
    end

    rows = '{
      // reset settings: delay one, gain one half
      '{RowPair, CfgDelay, 16'h7FFF, 16'h8000, 1'b1, 16'h0000, 16'h0000},
      '{RowPair, CfgDelay, 16'h0000, 16'h0000, 1'b1, 16'h7FFF, 16'h8001},
      '{RowPair, CfgDelay, 16'hFFFF, 16'h0001, 1'b0, 16'h0000, 16'h0000},
      '{RowPair, CfgDelay, 16'h0001, 16'hFFFF, 1'b0, 16'h0000, 16'h0000},
      // writes to indexes with no register behind them
      '{RowReg,  CfgSpare, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
      '{RowReg,  CfgTop,   16'hFFFF, 16'h0000, 1'b0, 16'h0000, 16'h0000},
      '{RowPair, CfgDelay, 16'h0064, 16'hFF9C, 1'b0, 16'h0000, 16'h0000},
      // passthrough
      '{RowReg,  CfgDelay, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
      '{RowPair, CfgDelay, 16'h8000, 16'h7FFF, 1'b1, 16'h8001, 16'h7FFF},
      '{RowPair, CfgDelay, 16'h04D2, 16'hFFFB, 1'b1, 16'h04D2, 16'hFFFB},
      // short delay at full gain, driven into saturation
      '{RowReg,  CfgDelay, 16'h0003, 16'h0000, 1'b0, 16'h0000, 16'h0000},
      '{RowReg,  CfgGain,  16'hFFFF, 16'h0000, 1'b0, 16'h0000, 16'h0000},
      '{RowPair, CfgDelay, 16'h7FFF, 16'h7FFF, 1'b0, 16'h0000, 16'h0000},
      '{RowPair, CfgDelay, 16'h8000, 16'h8000, 1'b0, 16'h0000, 16'h0000},
      '{RowPair, CfgDelay, 16'h4E20, 16'hB1E0, 1'b0, 16'h0000, 16'h0000},
      '{RowPair, CfgDelay, 16'h5555, 16'hAAAA, 1'b0, 16'h0000, 16'h0000},
      '{RowPair, CfgDelay, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
      '{RowPair, CfgDelay, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
      // zero gain
      '{RowReg,  CfgGain,  16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
      '{RowPair, CfgDelay, 16'h1234, 16'h4321, 1'b0, 16'h0000, 16'h0000},
      '{RowPair, CfgDelay, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
      '{RowPair, CfgDelay, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
      // delay beyond the line length, smallest gain
      '{RowReg,  CfgDelay, 16'hFFFF, 16'h0000, 1'b0, 16'h0000, 16'h0000},
      '{RowReg,  CfgGain,  16'h0001, 16'h0000, 1'b0, 16'h0000, 16'h0000},
      '{RowPair, CfgDelay, 16'h7FFF, 16'h8000, 1'b0, 16'h0000, 16'h0000},
      '{RowPair, CfgDelay, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
      // shrink the delay below the pointer so it wraps
      '{RowReg,  CfgDelay, 16'h0002, 16'h0000, 1'b0, 16'h0000, 16'h0000},
      '{RowReg,  CfgGain,  16'h8000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
      '{RowPair, CfgDelay, 16'hAAAA, 16'h5555, 1'b0, 16'h0000, 16'h0000},
      '{RowPair, CfgDelay, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
      '{RowPair, CfgDelay, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
      '{RowPair, CfgDelay, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000}
    };

    // hold reset, then release it
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // walk the directed table
    foreach (rows[i]) begin
      if (rows[i].kind == RowReg) begin
        write_reg(rows[i].idx, rows[i].left);
      end else begin
        send_pair(rows[i].left, rows[i].right, rows[i].typed,
                  {rows[i].want_r, rows[i].want_l});
      end
    end

    // random bursts, each under fresh settings
    for (int b = 0; b < NumBursts; b++) begin
      logic [CfgDatW-1:0] dly;
      logic [CfgDatW-1:0] gain;
      case (b)
        0:  dly = 16'd1;
        1:  dly = 16'd2;
        2:  dly = 16'd0;
        3:  dly = CfgDatW'($urandom_range(8, 3));
        4:  dly = CfgDatW'(MaxDelay);
        5:  dly = CfgDatW'($urandom_range(64, 9));
        6:  dly = 16'd1;
        7:  dly = 16'hFFFF;
        8:  dly = CfgDatW'($urandom_range(5, 2));
        9:  dly = CfgDatW'($urandom_range(400, 65));
        10: dly = CfgDatW'($urandom_range(65534, MaxDelay + 1));
        default: dly = CfgDatW'($urandom_range(16, 1));
      endcase
      case ($urandom_range(5))
        0: gain = 16'h0000;
        1: gain = 16'hFFFF;
        default: gain = CfgDatW'($urandom);
      endcase
      write_reg(CfgDelay, dly);
      write_reg(CfgGain, gain);
      // run back to back on both sides through one single-delay burst
      calm = (b == 6);
      for (int n = 0; n < BurstLen; n++) begin
        if (b == 5 && n == BurstLen / 2) settle();
        send_pair(pick_sample(), pick_sample(), 1'b0, '0);
      end
      calm = 1'b0;
    end

    // drain and report
    settle();
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("stereo_feedback_delay_echo_unit test passed");
    end else begin
      $display("stereo_feedback_delay_echo_unit test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/sfde_pkg.sv
rtl/sfde_ram.sv
rtl/sfde_lane.sv
rtl/stereo_feedback_delay_echo_unit.sv
verif/tb_stereo_feedback_delay_echo_unit.sv
